// ===== rtl/pid2i_pkg.sv =====
// ----------------------------------------------------------------------------
// pid2i_pkg
// Shared types, constants and saturation helpers for the PID controller.
// ----------------------------------------------------------------------------
package pid2i_pkg;

    localparam int DATA_W = 32;   // Q16.16 samples, gains and parts
    localparam int TIME_W = 31;   // Ti and Td, unsigned Q15.16
    localparam int SUM_W  = 48;   // Q32.16 integral sum and wide terms
    localparam int IDX_W  = 2;
    localparam int ACC_W  = 64;   // product magnitude after the >>16

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [TIME_W-1:0]        t_time;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TI    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TD    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_IMODE = 2'd3;

    // which product the shared multiplier is working on
    typedef enum logic [1:0] {
        MOP_P  = 2'd0,   // gain * e
        MOP_D1 = 2'd1,   // Td * (e - previous e)
        MOP_D2 = 2'd2,   // gain * dterm
        MOP_I  = 2'd3    // gain * integral term
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    mul_lo;
        logic    mul_hi;
        logic    mul_acc;
        logic    mul_wr;
        t_mul_op op;
        logic    div_start;
        logic    sum_upd;
        logic    itemp_q;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic ti_zero;
        logic mode;
        logic div_busy;
    } t_stat;

    // magnitude of a 48-bit signed value; -2^47 maps to 2^47
    function automatic logic [SUM_W-1:0] f_mag48(input t_sum v);
        logic [SUM_W-1:0] u;
        u = v;
        return v[SUM_W-1] ? (~u + 1'b1) : u;
    endfunction

    // sign and magnitude to saturated 32-bit signed
    function automatic t_data f_sat32(input logic neg, input logic [ACC_W-1:0] m);
        logic [DATA_W-1:0] lo;
        lo = m[DATA_W-1:0];
        if (neg) begin
            if (m > ACC_W'(64'h0000_0000_8000_0000))
                return t_data'({1'b1, {(DATA_W-1){1'b0}}});
            return t_data'(~lo + 1'b1);
        end
        if (m > ACC_W'(64'h0000_0000_7FFF_FFFF))
            return t_data'({1'b0, {(DATA_W-1){1'b1}}});
        return t_data'(lo);
    endfunction

    // sign and magnitude to saturated 48-bit signed
    function automatic t_sum f_sat48(input logic neg, input logic [ACC_W-1:0] m);
        logic [SUM_W-1:0] lo;
        lo = m[SUM_W-1:0];
        if (neg) begin
            if (m > ACC_W'(64'h0000_8000_0000_0000))
                return t_sum'({1'b1, {(SUM_W-1){1'b0}}});
            return t_sum'(~lo + 1'b1);
        end
        if (m > ACC_W'(64'h0000_7FFF_FFFF_FFFF))
            return t_sum'({1'b0, {(SUM_W-1){1'b1}}});
        return t_sum'(lo);
    endfunction

endpackage

// ===== rtl/pid_controller_two_integral_modes.sv =====
// ----------------------------------------------------------------------------
// pid_controller_two_integral_modes
// Discrete Q16.16 PID controller with inner or outer integral division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one error sample per
//   request plus a flag that clears the integral sum and previous error first.
//   Output channel (o_out_valid / i_out_ready) returns drive and the P, I and
//   D parts, each saturated signed Q16.16, one result per request.
//   Configuration: i_cfg_we writes register i_cfg_idx (0 gain, 1 Ti, 2 Td,
//   3 integral mode); write only while no request is in flight.
//   Datapath: one shared 32x24 multiplier forms up to four products, each in
//   the steps low half, high half, accumulate and write; the integral term
//   adds a 48-step bit-serial divide by Ti. With Ti = 0 the divide and the
//   integral product are skipped.
//   One request is worked at a time. The result waits in an output register,
//   so the next request is accepted while the previous result is unread; a
//   stalled receiver only holds the block at its final step.
//   Reset (synchronous, active low) zeroes all configuration, the integral sum
//   and the previous error, and empties the output register.
// ----------------------------------------------------------------------------
module pid_controller_two_integral_modes
    import pid2i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_data             i_error_sample,
    input  logic              i_clear_memory,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_data             o_drive,
    output t_data             o_p_part,
    output t_data             o_i_part,
    output t_data             o_d_part
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    pid2i_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // sample is latched on the accept edge, so the payload is only read then
    pid2i_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_error_sample (i_error_sample),
        .i_clear_memory (i_clear_memory),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_drive        (o_drive),
        .o_p_part       (o_p_part),
        .o_i_part       (o_i_part),
        .o_d_part       (o_d_part)
    );

endmodule

// ===== rtl/pid2i_div.sv =====
// ----------------------------------------------------------------------------
// pid2i_div
// Bit-serial restoring divider: (|x| << 16) / Ti, one quotient bit a cycle,
// signed and saturated to 48 bits.
// ----------------------------------------------------------------------------
module pid2i_div
    import pid2i_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_sum  i_dividend,
    input  t_time i_divisor,
    output logic  o_busy,
    output t_sum  o_quot
);

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [SUM_W-1:0] r_num;     // dividend bits in, quotient bits out
    logic             r_neg;
    logic             r_ovf;     // quotient needs more than 48 bits

    logic [SUM_W-1:0]  mag;
    logic [TIME_W:0]   trial;
    logic              ge;

    always_comb begin
        mag   = f_mag48(i_dividend);
        trial = {r_rem, r_num[SUM_W-1]};
        ge    = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(SUM_W - 1))
                r_busy <= 1'b0;
            else
                r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // top 16 magnitude bits seed the remainder; the rest plus 16 zeros shift in
            r_rem <= TIME_W'(mag[SUM_W-1:DATA_W]);
            r_num <= {mag[DATA_W-1:0], {(SUM_W-DATA_W){1'b0}}};
            r_neg <= i_dividend[SUM_W-1];
            r_ovf <= (TIME_W'(mag[SUM_W-1:DATA_W]) >= i_divisor);
        end else if (r_busy) begin
            r_rem <= ge ? TIME_W'(trial - {1'b0, i_divisor}) : trial[TIME_W-1:0];
            r_num <= {r_num[SUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = f_sat48(r_neg, r_ovf ? {ACC_W{1'b1}} : ACC_W'(r_num));

endmodule

// ===== rtl/pid2i_dp.sv =====
// ----------------------------------------------------------------------------
// pid2i_dp
// Datapath: configuration registers, controller state (sum, previous error),
// shared 32x24 multiplier, divider and result registers.
// ----------------------------------------------------------------------------
module pid2i_dp
    import pid2i_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    input  t_data            i_error_sample,
    input  logic             i_clear_memory,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output t_data            o_drive,
    output t_data            o_p_part,
    output t_data            o_i_part,
    output t_data            o_d_part
);

    localparam int HALF_W = SUM_W / 2;           // 24-bit slices of the b operand
    localparam int PROD_W = DATA_W + HALF_W;

    // configuration
    t_data r_gain;
    t_time r_ti;
    t_time r_td;
    logic  r_mode;

    // architectural state
    t_sum  r_sum;
    t_data r_prev;

    // per-request working registers
    t_data             r_e;
    t_data             r_p;
    t_data             r_ip;
    t_data             r_dp;
    t_sum              r_dterm;
    t_sum              r_itemp;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_mneg;

    // result registers
    t_data r_o_drive;
    t_data r_o_p;
    t_data r_o_ip;
    t_data r_o_dp;

    t_sum              e48;
    t_sum              diff48;
    t_sum              mul_b;
    logic              a_neg;
    logic [DATA_W-1:0] a_mag;
    logic [SUM_W-1:0]  b_mag;
    logic [HALF_W-1:0] b_part;
    t_sum              quot;
    t_sum              div_x;
    t_sum              sum_next;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [DATA_W+1:0] drive_wide;
    t_data             drive;
    logic              div_busy;

    function automatic t_sum f_clip48(input logic signed [SUM_W:0] s);
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? t_sum'({1'b1, {(SUM_W-1){1'b0}}})
                            : t_sum'({1'b0, {(SUM_W-1){1'b1}}});
        return t_sum'(s[SUM_W-1:0]);
    endfunction

    always_comb begin
        e48    = t_sum'(r_e);
        diff48 = t_sum'(e48 - t_sum'(r_prev));    // fits in 33 bits
        div_x  = r_mode ? r_sum : e48;

        case (i_cmd.op)
            MOP_P:   mul_b = e48;
            MOP_D1:  mul_b = diff48;
            MOP_D2:  mul_b = r_dterm;
            MOP_I:   mul_b = r_itemp;
            default: mul_b = e48;
        endcase

        if (i_cmd.op == MOP_D1) begin
            a_neg = 1'b0;
            a_mag = DATA_W'(r_td);
        end else begin
            a_neg = r_gain[DATA_W-1];
            a_mag = r_gain[DATA_W-1] ? (~r_gain + 1'b1) : r_gain;
        end
        b_mag  = f_mag48(mul_b);
        b_part = i_cmd.mul_hi ? b_mag[SUM_W-1:HALF_W] : b_mag[HALF_W-1:0];

        // inner mode adds the quotient, outer mode adds e
        sum_wide = r_mode ? ((SUM_W+1)'(r_sum) + (SUM_W+1)'(e48))
                          : ((SUM_W+1)'(r_sum) + (SUM_W+1)'(quot));
        sum_next = f_clip48(sum_wide);

        drive_wide = (DATA_W+2)'(r_p) + (DATA_W+2)'(r_ip) + (DATA_W+2)'(r_dp);
        if (drive_wide[DATA_W+1:DATA_W-1] == 3'b000 || drive_wide[DATA_W+1:DATA_W-1] == 3'b111)
            drive = t_data'(drive_wide[DATA_W-1:0]);
        else
            drive = drive_wide[DATA_W+1] ? t_data'({1'b1, {(DATA_W-1){1'b0}}})
                                         : t_data'({1'b0, {(DATA_W-1){1'b1}}});
    end

    pid2i_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_x),
        .i_divisor  (r_ti),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    // configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_ti   <= '0;
            r_td   <= '0;
            r_mode <= 1'b0;
            r_sum  <= '0;
            r_prev <= '0;
        end else begin
            if (i_cmd.load && i_clear_memory) begin
                r_sum  <= '0;
                r_prev <= '0;
            end
            if (i_cmd.sum_upd)
                r_sum <= sum_next;
            if (i_cmd.out_load)
                r_prev <= r_e;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN:  r_gain <= t_data'(i_cfg_wdata);
                    CFG_TI:    r_ti   <= i_cfg_wdata[TIME_W-1:0];
                    CFG_TD:    r_td   <= i_cfg_wdata[TIME_W-1:0];
                    CFG_IMODE: begin
                        // a mode change restarts the integral
                        if (i_cfg_wdata[0] != r_mode)
                            r_sum <= '0;
                        r_mode <= i_cfg_wdata[0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e  <= i_error_sample;
            r_ip <= '0;
        end
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(a_mag) * PROD_W'(b_part);
            r_mneg <= a_neg ^ mul_b[SUM_W-1];
        end
        if (i_cmd.mul_hi) begin
            r_prod <= PROD_W'(a_mag) * PROD_W'(b_part);
            r_acc  <= ACC_W'(r_prod[PROD_W-1:16]);
        end
        if (i_cmd.mul_acc)
            r_acc <= r_acc + ACC_W'({r_prod, 8'b0});
        if (i_cmd.mul_wr) begin
            case (i_cmd.op)
                MOP_P:   r_p     <= f_sat32(r_mneg, r_acc);
                MOP_D1:  r_dterm <= f_sat48(r_mneg, r_acc);
                MOP_D2:  r_dp    <= f_sat32(r_mneg, r_acc);
                MOP_I:   r_ip    <= f_sat32(r_mneg, r_acc);
                default: r_p     <= f_sat32(r_mneg, r_acc);
            endcase
        end
        if (i_cmd.sum_upd && !r_mode)
            r_itemp <= sum_next;
        if (i_cmd.itemp_q)
            r_itemp <= quot;
        if (i_cmd.out_load) begin
            r_o_drive <= drive;
            r_o_p     <= r_p;
            r_o_ip    <= r_ip;
            r_o_dp    <= r_dp;
        end
    end

    assign o_stat.ti_zero  = (r_ti == '0);
    assign o_stat.mode     = r_mode;
    assign o_stat.div_busy = div_busy;

    assign o_drive  = r_o_drive;
    assign o_p_part = r_o_p;
    assign o_i_part = r_o_ip;
    assign o_d_part = r_o_dp;

    a_ip_zero_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_ti == '0) |-> (r_ip == '0))
        else $error("integral part nonzero with integral disabled");

endmodule

// ===== rtl/pid2i_ctrl.sv =====
// ----------------------------------------------------------------------------
// pid2i_ctrl
// Sequencer: orders the four products, the divide and the sum update, and
// owns both handshakes.
// ----------------------------------------------------------------------------
module pid2i_ctrl
    import pid2i_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MLO    = 10'b00_0000_0010,
        S_MHI    = 10'b00_0000_0100,
        S_MACC   = 10'b00_0000_1000,
        S_MWR    = 10'b00_0001_0000,
        S_DSTART = 10'b00_0010_0000,
        S_DWAIT  = 10'b00_0100_0000,
        S_SUM    = 10'b00_1000_0000,
        S_ITEMP  = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_mul_op r_op, n_op;
    logic    r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.op = r_op;

        if (r_ovalid && i_out_ready)
            n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = MOP_P;
                    n_state    = S_MLO;
                end
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MACC;
            end
            S_MACC: begin
                o_cmd.mul_acc = 1'b1;
                n_state       = S_MWR;
            end
            S_MWR: begin
                o_cmd.mul_wr = 1'b1;
                case (r_op)
                    MOP_P: begin
                        n_op    = MOP_D1;
                        n_state = S_MLO;
                    end
                    MOP_D1: begin
                        n_op    = MOP_D2;
                        n_state = S_MLO;
                    end
                    MOP_D2: begin
                        if (i_stat.ti_zero)
                            n_state = S_FIN;
                        else if (!i_stat.mode)
                            n_state = S_DSTART;
                        else
                            n_state = S_SUM;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_stat.div_busy)
                    n_state = i_stat.mode ? S_ITEMP : S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_upd = 1'b1;
                if (i_stat.mode) begin
                    n_state = S_DSTART;
                end else begin
                    n_op    = MOP_I;
                    n_state = S_MLO;
                end
            end
            S_ITEMP: begin
                o_cmd.itemp_q = 1'b1;
                n_op          = MOP_I;
                n_state       = S_MLO;
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= MOP_P;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("result valid raised outside the finish step");

endmodule
